@@ design/slwm_pkg.sv @@
// Shared types and constants for the sound level window meter.
package slwm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CENTRED_W = 13;
    localparam int LEVEL_W   = 12;
    localparam int DB_W      = 9;

    localparam logic [SAMPLE_W-1:0] DC_OFFSET_RESET = 12'd2048;

    localparam logic [LEVEL_W-1:0] DB_KNEE     = 12'd100;
    localparam logic [DB_W-1:0]    DB_LOW_BASE = 9'd40;
    localparam logic [DB_W-1:0]    DB_HIGH_BASE = 9'd60;
    // x/5 == (x*205)>>10 for x below 1024
    localparam logic [7:0]         DIV5_MUL    = 8'd205;
    localparam int                 DIV5_SHIFT  = 10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/slwm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module slwm_div #(
    parameter int N = 18,
    parameter int D = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [N-1:0]        dividend,
    input  logic [D-1:0]        divisor,
    output logic [N-1:0]        quotient,
    output slwm_pkg::div_stat_t stat
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [D:0]    shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[N-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(N);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = D'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = shifted[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ design/sound_level_window_meter.sv @@
// Windowed sound level meter: DC removal, moving average of magnitudes, dB map.
//
// s_ channel: one raw 12-bit ADC sample per beat.
// m_ channel: one result beat per sample: centred sample, level and dB figure.
// cfg channel: writes the DC offset; always ready, write it while idle.
// One sample is processed at a time. After a sample beat the block reads the
// oldest magnitude from the ring memory, updates the running sum, then divides
// the sum by the sample count with a bit-serial divider (one bit per cycle
// over the sum width) and maps the level to dB. s_tready returns in the same
// cycle as the result enters the output register, so the next sample is
// taken only once the last one is through the divider and the dB map.
// The result sits in an output register; a stalled receiver holds it there
// and the next sample is taken meanwhile, its result waiting until the
// register empties.
// Reset clears the sum, the count, the pointer and the pipeline and sets the
// offset to 2048; the ring memory is not cleared, entries are read only once
// written.
module sound_level_window_meter #(
    parameter int WINDOW = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [12:0] centred_sample, [24:13] level, [33:25] db_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    localparam int SUM_W = $clog2(WINDOW * 4095 + 1);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int PW    = $clog2(WINDOW);
    localparam int CW    = slwm_pkg::CENTRED_W;
    localparam int LW    = slwm_pkg::LEVEL_W;
    localparam int DW    = slwm_pkg::DB_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DB   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [11:0]     dc_reg;
    logic [CW-1:0]   centred_reg, centred_next;
    logic [LW-1:0]   mag_reg, mag_next;
    logic [LW-1:0]   level_reg, level_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    logic [LW-1:0]   ring_rd_reg;
    logic            ring_we;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0]   out_centred_reg, out_centred_next;
    logic [LW-1:0]   out_level_reg, out_level_next;
    logic [DW-1:0]   out_db_reg, out_db_next;
    logic            div_start;
    logic [SUM_W-1:0] quotient;
    slwm_pkg::div_stat_t div_stat;

    logic [LW-1:0]   ring_mem [WINDOW];

    logic            full;
    logic            below_knee;
    logic [LW-1:0]   over_knee;
    logic [9:0]      mul_in;
    logic [17:0]     product;
    logic [DW-1:0]   db_value;

    assign full      = (fill_reg == FW'(WINDOW));
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // dB map: below the knee level/5 + 40, else (level-100)/20 + 60
    assign below_knee = (level_reg < slwm_pkg::DB_KNEE);
    assign over_knee  = level_reg - slwm_pkg::DB_KNEE;
    assign mul_in     = below_knee ? level_reg[9:0] : over_knee[11:2];
    assign product    = mul_in * slwm_pkg::DIV5_MUL;
    assign db_value   = (below_knee ? slwm_pkg::DB_LOW_BASE : slwm_pkg::DB_HIGH_BASE)
                        + DW'(product[17:slwm_pkg::DIV5_SHIFT]);

    always_comb begin
        state_next       = state_reg;
        centred_next     = centred_reg;
        mag_next         = mag_reg;
        level_next       = level_reg;
        sum_next         = sum_reg;
        fill_next        = fill_reg;
        ptr_next         = ptr_reg;
        ring_we          = 1'b0;
        div_start        = 1'b0;
        m_tvalid_next    = m_tvalid_reg;
        out_centred_next = out_centred_reg;
        out_level_next   = out_level_reg;
        out_db_next      = out_db_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    centred_next = {1'b0, s_tdata[11:0]} - {1'b0, dc_reg};
                    mag_next     = centred_next[CW-1] ? LW'(-centred_next)
                                                      : centred_next[LW-1:0];
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (full) begin
                    sum_next = sum_reg + SUM_W'(mag_reg) - SUM_W'(ring_rd_reg);
                end else begin
                    sum_next  = sum_reg + SUM_W'(mag_reg);
                    fill_next = fill_reg + FW'(1);
                end
                ring_we    = 1'b1;
                ptr_next   = (ptr_reg == PW'(WINDOW - 1)) ? '0 : ptr_reg + PW'(1);
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    level_next = quotient[LW-1:0];
                    state_next = ST_DB;
                end
            end
            ST_DB: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next    = 1'b1;
                    out_centred_next = centred_reg;
                    out_level_next   = level_reg;
                    out_db_next      = db_value;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ptr_reg] <= mag_reg;
        end
        ring_rd_reg <= ring_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        centred_reg     <= centred_next;
        mag_reg         <= mag_next;
        level_reg       <= level_next;
        out_centred_reg <= out_centred_next;
        out_level_reg   <= out_level_next;
        out_db_reg      <= out_db_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            dc_reg       <= slwm_pkg::DC_OFFSET_RESET;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                dc_reg <= cfg_data;
            end
        end
    end

    slwm_div #(
        .N (SUM_W),
        .D (FW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_db_reg, out_level_reg, out_centred_reg};

endmodule

@@ design/slwm_checker.sv @@
// Port-level checks for the sound level window meter, bound to the top level.
module slwm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while previous one in work");

    a_db_knee: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[24:13] < 12'd100) == (m_tdata[33:25] < 9'd60))
                     && (m_tdata[33:25] >= 9'd40))
        else $error("dB figure inconsistent with level");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:34] == 6'd0)
        else $error("padding bits of result not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind sound_level_window_meter slwm_checker u_slwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sound_level_window_meter_tb.sv @@
// Self-checking testbench for the sound level window meter: random and directed samples, offsets.
`timescale 1ns / 100ps

module testbench;

    localparam int WIN         = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [slwm_pkg::CENTRED_W-1:0] centred;
        logic [slwm_pkg::LEVEL_W-1:0]          level;
        logic [slwm_pkg::DB_W-1:0]             db;
    } meter_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data  = '0;

    logic [slwm_pkg::SAMPLE_W-1:0] sample_q[$];
    meter_result_t                 level_results_q[$];

    // own copy of the meter state
    logic [slwm_pkg::SAMPLE_W-1:0] offset_model = slwm_pkg::DC_OFFSET_RESET;
    logic [slwm_pkg::LEVEL_W-1:0]  mag_ring[WIN];
    int unsigned         sum_model  = 0;
    int unsigned         fill_model = 0;
    int unsigned         ptr_model  = 0;

    int tx_idle_pct = 25;
    int rx_idle_pct = 60;
    int beats_in    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int errors      = 0;
    int cycle_count = 0;

    sound_level_window_meter #(.WINDOW(WIN)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [11:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [12:0] centred_sample, [24:13] level, [33:25] db_value
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic advance_meter(input logic [slwm_pkg::SAMPLE_W-1:0] raw,
                                 output meter_result_t res);
        int          centred;
        int unsigned mag;
        int unsigned lvl;
        int unsigned db;
        centred = int'(raw) - int'(offset_model);
        mag = (centred < 0) ? -centred : centred;
        sum_model += mag;
        if (fill_model < WIN) begin
            fill_model++;
        end else begin
            sum_model -= mag_ring[ptr_model];
        end
        mag_ring[ptr_model] = mag[slwm_pkg::LEVEL_W-1:0];
        ptr_model = (ptr_model + 1 >= WIN) ? 0 : ptr_model + 1;
        lvl = sum_model / fill_model;
        if (lvl > 4095) begin
            lvl = 4095;
        end
        if (lvl < 100) begin
            db = 40 + (2 * lvl) / 10;
        end else begin
            db = 60 + (lvl - 100) / 20;
        end
        res.centred = centred[slwm_pkg::CENTRED_W-1:0];
        res.level   = lvl[slwm_pkg::LEVEL_W-1:0];
        res.db      = db[slwm_pkg::DB_W-1:0];
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endtask

    always @(posedge aclk) begin : sample_driver
        meter_result_t want;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_meter(s_tdata[slwm_pkg::SAMPLE_W-1:0], want);
                level_results_q.push_back(want);
                void'(sample_q.pop_front());
                beats_in <= beats_in + 1;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, sample_q[0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_in == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        meter_result_t want;
        meter_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.centred = m_tdata[12:0];
                got.level   = m_tdata[24:13];
                got.db      = m_tdata[33:25];
                if (level_results_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat c=%0d l=%0d db=%0d",
                                            got.centred, got.level, got.db));
                end else begin
                    want = level_results_q.pop_front();
                    if (got.centred !== want.centred) begin
                        note_mismatch($sformatf("centred exp %0d got %0d",
                                                want.centred, got.centred));
                    end
                    if (got.level !== want.level) begin
                        note_mismatch($sformatf("level exp %0d got %0d",
                                                want.level, got.level));
                    end
                    if (got.db !== want.db) begin
                        note_mismatch($sformatf("db exp %0d got %0d", want.db, got.db));
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_offset(input logic [slwm_pkg::SAMPLE_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        offset_model = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || level_results_q.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
    endtask

    task automatic queue_random(input int n);
        int pick;
        int v;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                v = int'(offset_model) + $urandom_range(300) - 150;
            end else if (pick < 60) begin
                v = int'(offset_model) + $urandom_range(40) - 20;
            end else if (pick < 85) begin
                v = $urandom_range(4095);
            end else begin
                v = $urandom_range(1) ? 4095 : 0;
            end
            if (v < 0) begin
                v = 0;
            end else if (v > 4095) begin
                v = 4095;
            end
            sample_q.push_back(v[slwm_pkg::SAMPLE_W-1:0]);
        end
    endtask

    initial begin
        logic [slwm_pkg::SAMPLE_W-1:0] offsets[5];
        offsets[0] = 12'd0;
        offsets[1] = 12'd4095;
        offsets[2] = 12'($urandom_range(4095));
        offsets[3] = 12'($urandom_range(4095));
        offsets[4] = slwm_pkg::DC_OFFSET_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset offset: zero, extremes, alternating bits
        @(negedge aclk);
        sample_q = '{12'd2048, 12'd4095, 12'd0, 12'd2047, 12'd2049, 12'hAAA, 12'h555};
        wait_drained();

        // zero offset; ring keeps old magnitudes
        write_offset(12'd0);
        @(negedge aclk);
        sample_q = '{12'd0, 12'd99, 12'd101, 12'd4095, 12'd1, 12'd100, 12'd0};
        wait_drained();

        write_offset(12'd4095);
        @(negedge aclk);
        sample_q = '{12'd0, 12'd4095, 12'd4094, 12'd1, 12'd3995, 12'd0};
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            if (p < 2) begin
                tx_idle_pct = 25;
                rx_idle_pct = 60;
            end else if (p < 4) begin
                tx_idle_pct = 60;
                rx_idle_pct = 25;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_offset(offsets[p]);
            @(negedge aclk);
            queue_random(126);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && level_results_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
